>>> design/hctb_pkg.sv
// ---------------------------------------------------------------------------
// hctb_pkg
// Shared opcodes, datapath command codes and the status bundle of the
// huffman code table builder.
// ---------------------------------------------------------------------------
package hctb_pkg;

    // fixed field widths of the item ports
    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int FREQ_W  = 32;
    localparam int CODE_W  = 63;
    localparam int LEN_W   = 6;
    localparam int CNT_W   = 9;

    // item opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // datapath commands
    localparam int CMD_W = 5;
    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_NONE       = 5'd0;
    localparam t_cmd CMD_SIMPLE     = 5'd1;
    localparam t_cmd CMD_BUILD_INIT = 5'd2;
    localparam t_cmd CMD_SCAN_CHK   = 5'd3;
    localparam t_cmd CMD_INS_RD     = 5'd4;
    localparam t_cmd CMD_INS_CHK    = 5'd5;
    localparam t_cmd CMD_SCAN_NEXT  = 5'd6;
    localparam t_cmd CMD_MERGE_INIT = 5'd7;
    localparam t_cmd CMD_ONE        = 5'd8;
    localparam t_cmd CMD_TAKE_CHK   = 5'd9;
    localparam t_cmd CMD_MERGE_WA   = 5'd10;
    localparam t_cmd CMD_MERGE_WB   = 5'd11;
    localparam t_cmd CMD_CODE_INIT  = 5'd12;
    localparam t_cmd CMD_CODE_CHK   = 5'd13;
    localparam t_cmd CMD_WALK_RD    = 5'd14;
    localparam t_cmd CMD_WALK_CHK   = 5'd15;
    localparam t_cmd CMD_CODE_NEXT  = 5'd16;
    localparam t_cmd CMD_FINISH     = 5'd17;

    // datapath status toward the controller
    typedef struct packed {
        logic present;      // current symbol has a nonzero weight
        logic sym_last;     // symbol counter at the last symbol
        logic k_zero;       // insert position reached queue head
        logic shift;        // queue entry heavier than the new leaf
        logic count_zero;
        logic count_one;
        logic second;       // next pick is the right child
        logic merges_done;  // last merge being written
        logic at_root;
        logic too_deep;
    } t_dp_stat;

endpackage

>>> design/hctb_ctrl.sv
// ---------------------------------------------------------------------------
// hctb_ctrl
// Sequencer of the code table builder: takes items and steps the datapath
// through sort, merge and code walk phases of a build.
// ---------------------------------------------------------------------------
module hctb_ctrl
    import hctb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] i_opcode,
    input  t_dp_stat        i_stat,
    output t_cmd            o_cmd,
    output logic            busy
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SCAN_RD   = 5'd1;
    localparam logic [4:0] S_SCAN_CHK  = 5'd2;
    localparam logic [4:0] S_INS_RD    = 5'd3;
    localparam logic [4:0] S_INS_CHK   = 5'd4;
    localparam logic [4:0] S_SCAN_NEXT = 5'd5;
    localparam logic [4:0] S_SORTED    = 5'd6;
    localparam logic [4:0] S_ONE       = 5'd7;
    localparam logic [4:0] S_TAKE_RD   = 5'd8;
    localparam logic [4:0] S_TAKE_CHK  = 5'd9;
    localparam logic [4:0] S_MERGE_WA  = 5'd10;
    localparam logic [4:0] S_MERGE_WB  = 5'd11;
    localparam logic [4:0] S_CODE_INIT = 5'd12;
    localparam logic [4:0] S_CODE_RD   = 5'd13;
    localparam logic [4:0] S_CODE_CHK  = 5'd14;
    localparam logic [4:0] S_WALK_RD   = 5'd15;
    localparam logic [4:0] S_WALK_CHK  = 5'd16;
    localparam logic [4:0] S_CODE_NEXT = 5'd17;
    localparam logic [4:0] S_FINISH    = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_BUILD) begin
                        o_cmd   = CMD_BUILD_INIT;
                        n_state = S_SCAN_RD;
                    end else begin
                        o_cmd = CMD_SIMPLE;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd   = CMD_SCAN_CHK;
                n_state = i_stat.present ? S_INS_RD : S_SCAN_NEXT;
            end
            S_INS_RD: begin
                o_cmd   = CMD_INS_RD;
                n_state = i_stat.k_zero ? S_SCAN_NEXT : S_INS_CHK;
            end
            S_INS_CHK: begin
                o_cmd   = CMD_INS_CHK;
                n_state = i_stat.shift ? S_INS_RD : S_SCAN_NEXT;
            end
            S_SCAN_NEXT: begin
                o_cmd   = CMD_SCAN_NEXT;
                n_state = i_stat.sym_last ? S_SORTED : S_SCAN_RD;
            end
            S_SORTED: begin
                o_cmd = CMD_MERGE_INIT;
                if (i_stat.count_zero) begin
                    n_state = S_FINISH;
                end else if (i_stat.count_one) begin
                    n_state = S_ONE;
                end else begin
                    n_state = S_TAKE_RD;
                end
            end
            S_ONE: begin
                o_cmd   = CMD_ONE;
                n_state = S_FINISH;
            end
            S_TAKE_RD: begin
                n_state = S_TAKE_CHK;
            end
            S_TAKE_CHK: begin
                o_cmd   = CMD_TAKE_CHK;
                n_state = i_stat.second ? S_MERGE_WA : S_TAKE_RD;
            end
            S_MERGE_WA: begin
                o_cmd   = CMD_MERGE_WA;
                n_state = S_MERGE_WB;
            end
            S_MERGE_WB: begin
                o_cmd   = CMD_MERGE_WB;
                n_state = i_stat.merges_done ? S_CODE_INIT : S_TAKE_RD;
            end
            S_CODE_INIT: begin
                o_cmd   = CMD_CODE_INIT;
                n_state = S_CODE_RD;
            end
            S_CODE_RD: begin
                n_state = S_CODE_CHK;
            end
            S_CODE_CHK: begin
                o_cmd   = CMD_CODE_CHK;
                n_state = i_stat.present ? S_WALK_RD : S_CODE_NEXT;
            end
            S_WALK_RD: begin
                o_cmd   = CMD_WALK_RD;
                n_state = (i_stat.at_root || i_stat.too_deep) ? S_CODE_NEXT : S_WALK_CHK;
            end
            S_WALK_CHK: begin
                o_cmd   = CMD_WALK_CHK;
                n_state = S_WALK_RD;
            end
            S_CODE_NEXT: begin
                o_cmd   = CMD_CODE_NEXT;
                n_state = i_stat.sym_last ? S_FINISH : S_CODE_RD;
            end
            S_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a build always ends with exactly one finish step before idle
    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");

    // items are taken only in idle
    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_SIMPLE || o_cmd == CMD_BUILD_INIT) |-> !busy)
        else $error("item command issued while busy");

    // a merge write pair always follows the second pick
    a_merge_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE_WA) |=> (r_state == S_MERGE_WB))
        else $error("merge write pair broken");

endmodule

>>> design/hctb_dp.sv
// ---------------------------------------------------------------------------
// hctb_dp
// Datapath of the code table builder: weight store, sorted leaf queue,
// internal node queue, parent links, code table and result register.
// ---------------------------------------------------------------------------
module hctb_dp
    import hctb_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 63,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_frequency,
    output t_dp_stat          o_stat,
    output logic              o_done,
    output logic [CODE_W-1:0] o_code_bits,
    output logic [LEN_W-1:0]  o_code_length,
    output logic [CNT_W-1:0]  o_symbol_count,
    output logic              o_empty_flag
);

    localparam int SW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CW    = $clog2(SYMBOLS + 1);
    localparam int NW    = $clog2(2 * SYMBOLS);
    localparam int IW    = WEIGHT_BITS + SW + 1;
    localparam int NODES = 2 * SYMBOLS - 1;
    localparam int QW    = WEIGHT_BITS + SW;
    localparam int TW    = LEN_W + MAX_CODE_LEN;

    // memories
    logic [WEIGHT_BITS-1:0]  m_weight [SYMBOLS];
    logic [QW-1:0]           m_queue  [SYMBOLS];
    logic [IW-1:0]           m_inode  [SYMBOLS];
    logic [NW:0]             m_parent [NODES];
    logic [TW-1:0]           m_code   [SYMBOLS];

    logic [WEIGHT_BITS-1:0]  r_weight_q;
    logic                    r_wv_q;
    logic [QW-1:0]           r_queue_q;
    logic [IW-1:0]           r_inode_q;
    logic [NW:0]             r_parent_q;
    logic [TW-1:0]           r_code_q;

    logic [SYMBOLS-1:0]      r_wvalid;
    logic [SYMBOLS-1:0]      r_cvalid;

    // work registers
    logic [SW-1:0]           r_s;
    logic [CW-1:0]           r_qlen;
    logic [CW-1:0]           r_k;
    logic [WEIGHT_BITS-1:0]  r_new_w;
    logic [SW-1:0]           r_new_id;
    logic [CW-1:0]           r_count;
    logic [SW-1:0]           r_last_sym;
    logic [CW-1:0]           r_lp;
    logic [SW-1:0]           r_ip;
    logic [SW-1:0]           r_in;
    logic                    r_second;
    logic [NW-1:0]           r_a_id;
    logic [IW-1:0]           r_a_w;
    logic [NW-1:0]           r_b_id;
    logic [IW-1:0]           r_b_w;
    logic [NW-1:0]           r_node;
    logic [LEN_W-1:0]        r_depth;
    logic [MAX_CODE_LEN-1:0] r_code;

    // result registers
    logic                    r_done;
    logic                    r_rd_hit;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_empty;

    logic                    in_range;
    logic [SW-1:0]           sym_addr;
    logic                    present;
    logic [CW-1:0]           k_dec;
    logic [SW-1:0]           q_rd_addr;
    logic                    q_we;
    logic [SW-1:0]           q_wa;
    logic [QW-1:0]           q_wd;
    logic [WEIGHT_BITS-1:0]  lq_w;
    logic [SW-1:0]           lq_id;
    logic                    shift;
    logic                    leaf_av;
    logic                    int_av;
    logic                    pick_leaf;
    logic [NW-1:0]           pick_id;
    logic [IW-1:0]           pick_w;
    logic [NW-1:0]           next_id;
    logic [NW-1:0]           root_id;
    logic                    p_we;
    logic [NW-1:0]           p_wa;
    logic [NW:0]             p_wd;
    logic                    c_we;
    logic [SW-1:0]           c_wa;
    logic [TW-1:0]           c_wd;
    logic                    merges_done;

    assign in_range = (32'(i_symbol) < SYMBOLS);
    assign sym_addr = i_symbol[SW-1:0];
    assign present  = r_wv_q && (r_weight_q != '0);
    assign k_dec    = r_k - CW'(1);
    assign lq_w     = r_queue_q[QW-1:SW];
    assign lq_id    = r_queue_q[SW-1:0];
    assign shift    = (lq_w > r_new_w);
    assign next_id  = NW'(SYMBOLS) + NW'(r_in);
    assign root_id  = NW'(SYMBOLS) + NW'(r_count) - NW'(2);
    assign merges_done = ((CW'(r_in) + CW'(1)) == (r_count - CW'(1)));

    // two-queue pick: a leaf wins ties, matching a stable sorted insert
    assign leaf_av   = (r_lp < r_qlen);
    assign int_av    = (r_ip < r_in);
    assign pick_leaf = leaf_av && (!int_av || (IW'(lq_w) <= r_inode_q));
    assign pick_id   = pick_leaf ? NW'(lq_id) : (NW'(SYMBOLS) + NW'(r_ip));
    assign pick_w    = pick_leaf ? IW'(lq_w) : r_inode_q;

    // status bundle
    always_comb begin
        o_stat.present     = present;
        o_stat.sym_last    = (r_s == SW'(SYMBOLS - 1));
        o_stat.k_zero      = (r_k == '0);
        o_stat.shift       = shift;
        o_stat.count_zero  = (r_count == '0);
        o_stat.count_one   = (r_count == CW'(1));
        o_stat.second      = r_second;
        o_stat.merges_done = merges_done;
        o_stat.at_root     = (r_node == root_id);
        o_stat.too_deep    = (r_depth >= LEN_W'(MAX_CODE_LEN));
    end

    // queue port selection
    always_comb begin
        q_rd_addr = (i_cmd == CMD_INS_RD) ? k_dec[SW-1:0] : r_lp[SW-1:0];
        q_we      = 1'b0;
        q_wa      = r_k[SW-1:0];
        q_wd      = {r_new_w, r_new_id};
        if (i_cmd == CMD_INS_RD && r_k == '0) begin
            q_we = 1'b1;
        end else if (i_cmd == CMD_INS_CHK) begin
            q_we = 1'b1;
            if (shift) begin
                q_wd = r_queue_q;
            end
        end
    end

    // parent link writes
    always_comb begin
        p_we = 1'b0;
        p_wa = r_a_id;
        p_wd = {next_id, 1'b0};
        case (i_cmd)
            CMD_MERGE_WA: begin
                p_we = 1'b1;
            end
            CMD_MERGE_WB: begin
                p_we = 1'b1;
                p_wa = r_b_id;
                p_wd = {next_id, 1'b1};
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    // code table writes
    always_comb begin
        c_we = 1'b0;
        c_wa = r_s;
        c_wd = {r_depth, r_code};
        if (i_cmd == CMD_ONE) begin
            c_we = 1'b1;
            c_wa = r_last_sym;
            c_wd = {LEN_W'(1), MAX_CODE_LEN'(0)};
        end else if (i_cmd == CMD_WALK_RD && r_node == root_id) begin
            c_we = 1'b1;
        end
    end

    // weight store
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_SIMPLE && i_opcode == OP_LOAD && in_range) begin
            m_weight[sym_addr] <= i_frequency[WEIGHT_BITS-1:0];
        end
        r_weight_q <= m_weight[r_s];
        r_wv_q     <= r_wvalid[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_cmd == CMD_SIMPLE && i_opcode == OP_CLEAR) begin
            r_wvalid <= '0;
        end else if (i_cmd == CMD_SIMPLE && i_opcode == OP_LOAD && in_range) begin
            r_wvalid[sym_addr] <= 1'b1;
        end
    end

    // leaf queue
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_queue[q_wa] <= q_wd;
        end
        r_queue_q <= m_queue[q_rd_addr];
    end

    // internal node weights
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_MERGE_WA) begin
            m_inode[r_in] <= r_a_w + r_b_w;
        end
        r_inode_q <= m_inode[r_ip];
    end

    // parent links
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            m_parent[p_wa] <= p_wd;
        end
        r_parent_q <= m_parent[r_node];
    end

    // code table
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            m_code[c_wa] <= c_wd;
        end
        r_code_q <= m_code[sym_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (i_cmd == CMD_BUILD_INIT) begin
            r_cvalid <= '0;
        end else if (c_we) begin
            r_cvalid[c_wa] <= 1'b1;
        end
    end

    // build work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_BUILD_INIT: begin
                r_s     <= '0;
                r_qlen  <= '0;
                r_count <= '0;
            end
            CMD_SCAN_CHK: begin
                if (present) begin
                    r_k        <= r_qlen;
                    r_new_w    <= r_weight_q;
                    r_new_id   <= r_s;
                    r_count    <= r_count + CW'(1);
                    r_last_sym <= r_s;
                end
            end
            CMD_INS_RD: begin
                if (r_k == '0) begin
                    r_qlen <= r_qlen + CW'(1);
                end
            end
            CMD_INS_CHK: begin
                if (shift) begin
                    r_k <= k_dec;
                end else begin
                    r_qlen <= r_qlen + CW'(1);
                end
            end
            CMD_SCAN_NEXT, CMD_CODE_NEXT: begin
                r_s <= r_s + SW'(1);
            end
            CMD_MERGE_INIT: begin
                r_lp     <= '0;
                r_ip     <= '0;
                r_in     <= '0;
                r_second <= 1'b0;
            end
            CMD_TAKE_CHK: begin
                if (r_second) begin
                    r_b_id <= pick_id;
                    r_b_w  <= pick_w;
                end else begin
                    r_a_id <= pick_id;
                    r_a_w  <= pick_w;
                end
                r_second <= !r_second;
                if (pick_leaf) begin
                    r_lp <= r_lp + CW'(1);
                end else begin
                    r_ip <= r_ip + SW'(1);
                end
            end
            CMD_MERGE_WB: begin
                r_in <= r_in + SW'(1);
            end
            CMD_CODE_INIT: begin
                r_s <= '0;
            end
            CMD_CODE_CHK: begin
                r_node  <= NW'(r_s);
                r_depth <= '0;
                r_code  <= '0;
            end
            CMD_WALK_CHK: begin
                r_code  <= r_code | (MAX_CODE_LEN'(r_parent_q[0]) << r_depth);
                r_depth <= r_depth + LEN_W'(1);
                r_node  <= r_parent_q[NW:1];
            end
            default: begin
                r_s <= r_s;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_rd_hit <= 1'b0;
            r_cnt    <= '0;
            r_empty  <= 1'b0;
        end else begin
            r_done   <= (i_cmd == CMD_SIMPLE) || (i_cmd == CMD_FINISH);
            r_rd_hit <= (i_cmd == CMD_SIMPLE) && (i_opcode == OP_READ) && in_range
                        && r_cvalid[sym_addr];
            r_cnt    <= (i_cmd == CMD_FINISH) ? CNT_W'(r_count) : '0;
            r_empty  <= (i_cmd == CMD_FINISH) && (r_count == '0);
        end
    end

    assign o_done         = r_done;
    assign o_code_bits    = r_rd_hit ? CODE_W'(r_code_q[MAX_CODE_LEN-1:0]) : '0;
    assign o_code_length  = r_rd_hit ? r_code_q[TW-1:MAX_CODE_LEN] : '0;
    assign o_symbol_count = r_cnt;
    assign o_empty_flag   = r_empty;

    // insert position never passes the queue fill
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_INS_CHK) |-> (r_k <= r_qlen))
        else $error("insert position beyond queue fill");

    // every pick finds a node in one of the two queues
    a_pick_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_TAKE_CHK) |-> (leaf_av || int_av))
        else $error("pick from two empty queues");

    // a code entry written by a walk never exceeds the length bound
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_we |-> (c_wd[TW-1:MAX_CODE_LEN] <= LEN_W'(MAX_CODE_LEN)))
        else $error("code length over bound");

endmodule

>>> design/huffman_code_table_builder.sv
// ---------------------------------------------------------------------------
// huffman_code_table_builder
// Builds a huffman code table from per-symbol weights.
// ---------------------------------------------------------------------------
// Usage: drive i_opcode, i_symbol and i_frequency with start; an item is
// taken at an edge where start is high and busy is low. Every item gives
// one result, shown for a single cycle with o_done; the receiver cannot
// stall it, so it must take it then.
// Clear, load and read do not hold busy and may follow back to back;
// their result appears the cycle after the item is taken.
// Build holds busy high while it works: the scan reads every symbol's weight
// and puts each present symbol into the leaf queue by an insertion sort that
// moves heavier queue entries up one at a time; each merge picks two nodes
// from the leaf and internal queues and writes both parent links; the code
// walk follows each present symbol's parent links up to the root, one
// parent-link read per code bit. Its result (symbol count, empty flag) shows
// in the first cycle with busy low again, so a new item can be taken in
// that same cycle.
// Reset clears the weight store and the code table through valid bits;
// no clearing pass is needed and items are taken right away.
// ---------------------------------------------------------------------------
module huffman_code_table_builder
    import hctb_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 63,
    parameter int WEIGHT_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_frequency,
    output logic              busy,
    output logic              o_done,
    output logic [CODE_W-1:0] o_code_bits,
    output logic [LEN_W-1:0]  o_code_length,
    output logic [CNT_W-1:0]  o_symbol_count,
    output logic              o_empty_flag
);

    t_cmd     cmd;
    t_dp_stat stat;

    // sequencer
    hctb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // datapath
    hctb_dp #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_symbol       (i_symbol),
        .i_frequency    (i_frequency),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_code_bits    (o_code_bits),
        .o_code_length  (o_code_length),
        .o_symbol_count (o_symbol_count),
        .o_empty_flag   (o_empty_flag)
    );

    // a non-build item answers on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode != OP_BUILD) |=> o_done)
        else $error("missing result after single-cycle item");

    // a result never shows while a build is running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result during build");

    // empty flag only with a zero count, and no payload without a strobe
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty_flag |-> (o_symbol_count == '0))
        and (!o_done |-> (o_code_length == '0 && o_symbol_count == '0)))
        else $error("result fields inconsistent");

endmodule

>>> dv/hctb_checker.sv
// ---------------------------------------------------------------------------
// hctb_checker
// Scoreboard for the huffman code table builder: keeps its own weight store
// and code table, predicts the result of every accepted item and compares it
// field by field with the result strobed out by the block.
// ---------------------------------------------------------------------------
module hctb_checker
    import hctb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [FREQ_W-1:0] i_frequency,
    input  logic              o_done,
    input  logic [CODE_W-1:0] o_code_bits,
    input  logic [LEN_W-1:0]  o_code_length,
    input  logic [CNT_W-1:0]  o_symbol_count,
    input  logic              o_empty_flag,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM   = 256;
    localparam int NNODES = 2 * NSYM - 1;
    localparam int MAXLEN = 63;

    typedef struct {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [CNT_W-1:0]  symbol_count;
        logic              empty_flag;
    } t_result;

    // predicted block state
    logic [FREQ_W-1:0] sym_weight [NSYM];
    logic [CODE_W-1:0] code_tab   [NSYM];
    logic [LEN_W-1:0]  len_tab    [NSYM];

    // tree build scratch
    logic [39:0] node_wt     [NNODES];
    int          node_parent [NNODES];
    bit          node_side   [NNODES];
    int          heap_order  [NSYM];
    int          order_len;

    t_result expected_results [$];

    // stable ascending insert, new node after its equals
    function automatic void order_insert(int id);
        int pos;
        pos = 0;
        while (pos < order_len && node_wt[heap_order[pos]] <= node_wt[id])
            pos++;
        for (int k = order_len; k > pos; k--)
            heap_order[k] = heap_order[k-1];
        heap_order[pos] = id;
        order_len++;
    endfunction

    function automatic int order_pop();
        int id;
        id = heap_order[0];
        for (int k = 1; k < order_len; k++)
            heap_order[k-1] = heap_order[k];
        order_len--;
        return id;
    endfunction

    // rebuild the code table, returns the number of present symbols
    function automatic int build_code_table();
        int count, next_id, a, b, root, node, depth;
        logic [CODE_W-1:0] code;
        bit too_long;
        count   = 0;
        next_id = NSYM;
        order_len = 0;
        for (int s = 0; s < NSYM; s++) begin
            code_tab[s] = '0;
            len_tab[s]  = '0;
        end
        for (int s = 0; s < NSYM; s++) begin
            if (sym_weight[s] != 0) begin
                node_wt[s] = {8'd0, sym_weight[s]};
                order_insert(s);
                count++;
            end
        end
        if (count == 0)
            return 0;
        if (count == 1) begin
            a = order_pop();
            len_tab[a] = 6'd1;
            return 1;
        end
        while (order_len >= 2) begin
            a = order_pop();
            b = order_pop();
            node_wt[next_id]  = node_wt[a] + node_wt[b];
            node_parent[a]    = next_id;
            node_side[a]      = 1'b0;
            node_parent[b]    = next_id;
            node_side[b]      = 1'b1;
            order_insert(next_id);
            next_id++;
        end
        root = order_pop();
        for (int s = 0; s < NSYM; s++) begin
            if (sym_weight[s] != 0) begin
                node = s;
                depth = 0;
                code = '0;
                too_long = 1'b0;
                while (node != root) begin
                    if (depth >= MAXLEN) begin
                        too_long = 1'b1;
                        break;
                    end
                    code[depth] = node_side[node];
                    depth++;
                    node = node_parent[node];
                end
                if (!too_long) begin
                    code_tab[s] = code;
                    len_tab[s]  = depth[LEN_W-1:0];
                end
            end
        end
        return count;
    endfunction

    // expected result of one accepted item
    function automatic t_result predict_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                             logic [FREQ_W-1:0] freq);
        t_result r;
        int n;
        r = '{default: '0};
        case (op)
            OP_CLEAR: begin
                for (int s = 0; s < NSYM; s++) sym_weight[s] = '0;
            end
            OP_LOAD: begin
                sym_weight[sym] = freq;
            end
            OP_BUILD: begin
                n = build_code_table();
                r.symbol_count = n[CNT_W-1:0];
                r.empty_flag   = (n == 0);
            end
            default: begin
                r.code_bits   = code_tab[sym];
                r.code_length = len_tab[sym];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < NSYM; s++) begin
                sym_weight[s] = '0;
                code_tab[s]   = '0;
                len_tab[s]    = '0;
            end
            expected_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            // compare a strobed result with the oldest prediction
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item outstanding", $time);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_code_bits !== want.code_bits) begin
                        $display("%0t: code_bits exp %h got %h", $time,
                                 want.code_bits, o_code_bits);
                        o_fail_count++;
                    end
                    if (o_code_length !== want.code_length) begin
                        $display("%0t: code_length exp %0d got %0d", $time,
                                 want.code_length, o_code_length);
                        o_fail_count++;
                    end
                    if (o_symbol_count !== want.symbol_count) begin
                        $display("%0t: symbol_count exp %0d got %0d", $time,
                                 want.symbol_count, o_symbol_count);
                        o_fail_count++;
                    end
                    if (o_empty_flag !== want.empty_flag) begin
                        $display("%0t: empty_flag exp %0d got %0d", $time,
                                 want.empty_flag, o_empty_flag);
                        o_fail_count++;
                    end
                end
            end
            // predict each accepted item
            if (start === 1'b1 && busy === 1'b0)
                expected_results.push_back(predict_item(i_opcode, i_symbol, i_frequency));
            o_pending = expected_results.size();
        end
    end

endmodule

>>> dv/tb_huffman_code_table_builder.sv
// ---------------------------------------------------------------------------
// tb_huffman_code_table_builder
// Drives clear, load, build and read items into the code table builder with
// random gaps: a directed opening, then random weight sets built and read
// back, scored by hctb_checker.
// ---------------------------------------------------------------------------
module tb_huffman_code_table_builder
    import hctb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 950;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic [OP_W-1:0]   i_opcode;
    logic [SYM_W-1:0]  i_symbol;
    logic [FREQ_W-1:0] i_frequency;
    logic              busy;
    logic              o_done;
    logic [CODE_W-1:0] o_code_bits;
    logic [LEN_W-1:0]  o_code_length;
    logic [CNT_W-1:0]  o_symbol_count;
    logic              o_empty_flag;
    int                fail_count;
    int                pending;

    int cycles = 0;
    int item_count;
    int build_count;
    int read_count;
    int largest_set;

    huffman_code_table_builder dut (.*);

    hctb_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_symbol, .i_frequency,
        .o_done, .o_code_bits, .o_code_length, .o_symbol_count, .o_empty_flag,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // present one item and hold it until taken
    task automatic send_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                             logic [FREQ_W-1:0] freq);
        start       <= 1'b1;
        i_opcode    <= op;
        i_symbol    <= sym;
        i_frequency <= freq;
        do @(posedge i_clk); while (busy);
        item_count++;
        if (op == OP_BUILD) build_count++;
        if (op == OP_READ) read_count++;
    endtask

    // random idle gap with junk on the fields, mostly short
    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
        if (n > 0) begin
            start       <= 1'b0;
            i_opcode    <= OP_W'($urandom);
            i_symbol    <= SYM_W'($urandom);
            i_frequency <= $urandom;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [FREQ_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 4);
            1: return $urandom_range(1, 200);
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [FREQ_W-1:0] fa, fb, ft;
        int nsym;
        item_count = 0;
        build_count = 0;
        read_count = 0;
        largest_set = 0;
        start = 1'b0;
        i_opcode = OP_CLEAR;
        i_symbol = '0;
        i_frequency = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: table after reset, empty build, single symbol
        send_item(OP_READ, 8'd0, 32'd0);
        send_item(OP_BUILD, 8'd0, 32'd0);
        send_item(OP_READ, 8'd255, 32'd0);
        send_item(OP_LOAD, 8'd255, 32'hFFFF_FFFF);
        send_item(OP_BUILD, 8'd0, 32'd0);
        send_item(OP_READ, 8'd255, 32'd0);
        // two equal weights: lower index becomes left child
        send_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF);
        send_item(OP_BUILD, 8'd0, 32'd0);
        send_item(OP_READ, 8'd0, 32'd0);
        send_item(OP_READ, 8'd255, 32'd0);
        // clear keeps the code table, loading zero removes a symbol
        send_item(OP_CLEAR, 8'd0, 32'd0);
        send_item(OP_READ, 8'd0, 32'd0);
        send_item(OP_LOAD, 8'd7, 32'd5);
        send_item(OP_LOAD, 8'd9, 32'd3);
        send_item(OP_LOAD, 8'd7, 32'd0);
        send_item(OP_BUILD, 8'd0, 32'd0);
        send_item(OP_READ, 8'd9, 32'd0);
        send_item(OP_READ, 8'd7, 32'd0);
        // fibonacci weights give the deepest codes 32-bit weights allow
        send_item(OP_CLEAR, 8'd0, 32'd0);
        fa = 32'd1;
        fb = 32'd1;
        for (int s = 0; s < 47; s++) begin
            send_item(OP_LOAD, s[7:0], fa);
            ft = fa + fb;
            fa = fb;
            fb = ft;
        end
        send_item(OP_BUILD, 8'd0, 32'd0);
        send_item(OP_READ, 8'd0, 32'd0);
        send_item(OP_READ, 8'd1, 32'd0);
        send_item(OP_READ, 8'd46, 32'd0);
        largest_set = 47;

        // random weight sets: load, build, read back
        while (item_count < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0)
                send_item(OP_CLEAR, SYM_W'($urandom), $urandom);
            idle_gap();
            case ($urandom_range(0, 19))
                0:       nsym = 256;
                1, 2:    nsym = $urandom_range(20, 60);
                default: nsym = $urandom_range(0, 12);
            endcase
            if (nsym > largest_set) largest_set = nsym;
            if (nsym == 256) begin
                for (int s = 0; s < 256; s++) begin
                    send_item(OP_LOAD, s[7:0], rand_weight() | 32'd1);
                    idle_gap();
                end
            end else begin
                for (int s = 0; s < nsym; s++) begin
                    send_item(OP_LOAD, SYM_W'($urandom), rand_weight());
                    idle_gap();
                end
            end
            // occasional stray read before the build
            if ($urandom_range(0, 3) == 0)
                send_item(OP_READ, SYM_W'($urandom), $urandom);
            send_item(OP_BUILD, SYM_W'($urandom), $urandom);
            idle_gap();
            repeat ($urandom_range(2, 10)) begin
                send_item(OP_READ, SYM_W'($urandom), $urandom);
                idle_gap();
            end
        end
        start <= 1'b0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d items: %0d builds, %0d reads, largest weight set %0d",
                 item_count, build_count, read_count, largest_set);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
